// ----- sv/chrs_pkg.sv -----
// Shared types, codes and defaults for the chained hash row store.
// No dependencies; every other file of the block refers to this package.
package chrs_pkg;

    // Default sizes of the bucket table and of the node pool.
    localparam int BUCKETS_DEF = 1024;
    localparam int POOL_DEF    = 4096;

    // Request codes as they arrive on the action field.
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_MISS = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    // Decoded operation handed from the front end to the engine.
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LOOKUP,
        OP_REMOVE,
        OP_NONE
    } op_t;

    // One queued request.
    typedef struct packed {
        op_t         op;
        logic [63:0] key;
        logic [63:0] b_value;
        logic [63:0] c_value;
    } cmd_t;

    // Payload of one node in the pool.
    typedef struct packed {
        logic [63:0] key;
        logic [63:0] b_value;
        logic [63:0] c_value;
    } node_data_t;

endpackage

// ----- sv/chrs_front.sv -----
// Front end of the row store: accepts request items and decodes the action.
// Depends on chrs_pkg for the action codes and the queued command type.
module chrs_front (
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [63:0]          s_key,
    input  logic [63:0]          s_b_value,
    input  logic [63:0]          s_c_value,
    input  logic                 engine_busy,
    input  logic                 queue_full,
    output logic                 push,
    output chrs_pkg::cmd_t       push_cmd
);

    chrs_pkg::op_t op;

    // Map the raw action code onto an operation; unused codes map to OP_NONE and only return a miss.
    always_comb begin
        case (s_action)
            chrs_pkg::ACT_INSERT: op = chrs_pkg::OP_INSERT;
            chrs_pkg::ACT_LOOKUP: op = chrs_pkg::OP_LOOKUP;
            chrs_pkg::ACT_REMOVE: op = chrs_pkg::OP_REMOVE;
            default:              op = chrs_pkg::OP_NONE;
        endcase
    end

    // Items are taken whenever reset is released, the queue has room and the table is initialized.
    assign s_ready  = aresetn && !queue_full && !engine_busy;
    assign push     = s_valid && s_ready;
    assign push_cmd = '{op: op, key: s_key, b_value: s_b_value, c_value: s_c_value};

endmodule

// ----- sv/chrs_queue.sv -----
// Two-entry command queue between the front end and the engine.
// Depends on chrs_pkg for the command type.
module chrs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  chrs_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output chrs_pkg::cmd_t q_cmd
);

    chrs_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- sv/chrs_engine.sv -----
// Back end of the row store: bucket table, node pool, free list and chain walker.
// Depends on chrs_pkg for codes and types; fed by chrs_queue.
module chrs_engine #(
    parameter int BUCKETS = chrs_pkg::BUCKETS_DEF,
    parameter int POOL    = chrs_pkg::POOL_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  chrs_pkg::cmd_t q_cmd,
    output logic           pop,
    output logic           busy,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_status,
    output logic [63:0]    m_b_out,
    output logic [63:0]    m_c_out,
    output logic [12:0]    m_row_total
);

    localparam int NW = $clog2(POOL + 1);
    localparam int AW = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [NW-1:0] NIL   = NW'(POOL);
    localparam logic [BW-1:0] BMASK = BW'(BUCKETS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_INS_WALK,
        ST_FIND,
        ST_REM_FREE,
        ST_RESULT
    } state_t;

    // Memories.
    logic [NW-1:0]        heads_mem [BUCKETS];
    logic [NW-1:0]        link_mem  [POOL];
    chrs_pkg::node_data_t data_mem  [POOL];

    // Control and working registers.
    state_t         state_reg, state_next;
    chrs_pkg::cmd_t cmd_reg, cmd_next;
    logic [BW-1:0]  bkt_reg, bkt_next;
    logic [BW-1:0]  clr_reg, clr_next;
    logic [NW-1:0]  cur_reg, cur_next;
    logic [NW-1:0]  prev_reg, prev_next;
    logic [NW-1:0]  alloc_reg, alloc_next;
    logic [NW-1:0]  free_head_reg, free_head_next;
    logic [NW-1:0]  fresh_reg, fresh_next;
    logic [NW-1:0]  count_reg, count_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic [63:0]    res_b_reg, res_b_next;
    logic [63:0]    res_c_reg, res_c_next;
    logic           m_valid_reg, m_valid_next;
    logic [1:0]     m_status_reg, m_status_next;
    logic [63:0]    m_b_reg, m_b_next;
    logic [63:0]    m_c_reg, m_c_next;
    logic [12:0]    m_total_reg, m_total_next;

    // Read ports and their registered data.
    logic [BW-1:0]        heads_raddr;
    logic [NW-1:0]        heads_rd_reg;
    logic [NW-1:0]        node_raddr;
    logic [NW-1:0]        link_rd_reg;
    logic [NW-1:0]        link_addr_reg;
    logic                 link_fresh_reg;
    chrs_pkg::node_data_t data_rd_reg;

    // Write ports.
    logic                 heads_we;
    logic [BW-1:0]        heads_waddr;
    logic [NW-1:0]        heads_wdata;
    logic                 link_we;
    logic [NW-1:0]        link_waddr;
    logic [NW-1:0]        link_wdata;
    logic                 data_we;
    logic [NW-1:0]        data_waddr;

    logic [NW-1:0] link_eff;
    logic [BW-1:0] q_bkt;
    logic [31:0]   count_ext;

    // A node never allocated from the initial run still links to its successor.
    assign link_eff  = link_fresh_reg ? (link_addr_reg + NW'(1)) : link_rd_reg;
    assign q_bkt     = q_cmd.key[BW-1:0] & BMASK;
    assign count_ext = 32'(count_reg);

    assign pop         = (state_reg == ST_IDLE) && q_valid;
    assign busy        = (state_reg == ST_CLEAR);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_b_out     = m_b_reg;
    assign m_c_out     = m_c_reg;
    assign m_row_total = m_total_reg;

    // Sequencer: one request at a time, walking its chain one node per cycle.
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        bkt_next        = bkt_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        alloc_next      = alloc_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_b_next      = res_b_reg;
        res_c_next      = res_c_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_b_next        = m_b_reg;
        m_c_next        = m_c_reg;
        m_total_next    = m_total_reg;
        heads_raddr     = bkt_reg;
        node_raddr      = cur_reg;
        heads_we        = 1'b0;
        heads_waddr     = bkt_reg;
        heads_wdata     = NIL;
        link_we         = 1'b0;
        link_waddr      = cur_reg;
        link_wdata      = NIL;
        data_we         = 1'b0;
        data_waddr      = free_head_reg;

        case (state_reg)
            // Empty every bucket, one per cycle, after reset.
            ST_CLEAR: begin
                heads_we    = 1'b1;
                heads_waddr = clr_reg;
                heads_wdata = NIL;
                clr_next    = clr_reg + BW'(1);
                if (clr_reg == BMASK) begin
                    state_next = ST_IDLE;
                end
            end

            // Take a command; fetch its bucket head and the free-list successor.
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next    = q_cmd;
                    bkt_next    = q_bkt;
                    heads_raddr = q_bkt;
                    node_raddr  = free_head_reg;
                    state_next  = ST_HEAD;
                end
            end

            ST_HEAD: begin
                res_status_next = chrs_pkg::STS_MISS;
                res_b_next      = 64'd0;
                res_c_next      = 64'd0;
                case (cmd_reg.op)
                    chrs_pkg::OP_INSERT: begin
                        if (free_head_reg == NIL) begin
                            res_status_next = chrs_pkg::STS_FULL;
                            state_next      = ST_RESULT;
                        end else begin
                            // Pop the free list and write the new tail node.
                            res_status_next = chrs_pkg::STS_OK;
                            alloc_next      = free_head_reg;
                            free_head_next  = link_eff;
                            if (free_head_reg == fresh_reg) begin
                                fresh_next = fresh_reg + NW'(1);
                            end
                            count_next = count_reg + NW'(1);
                            data_we    = 1'b1;
                            data_waddr = free_head_reg;
                            link_we    = 1'b1;
                            link_waddr = free_head_reg;
                            link_wdata = NIL;
                            if (heads_rd_reg == NIL) begin
                                heads_we    = 1'b1;
                                heads_waddr = bkt_reg;
                                heads_wdata = free_head_reg;
                                state_next  = ST_RESULT;
                            end else begin
                                cur_next   = heads_rd_reg;
                                node_raddr = heads_rd_reg;
                                state_next = ST_INS_WALK;
                            end
                        end
                    end
                    chrs_pkg::OP_LOOKUP, chrs_pkg::OP_REMOVE: begin
                        if (heads_rd_reg == NIL) begin
                            state_next = ST_RESULT;
                        end else begin
                            cur_next   = heads_rd_reg;
                            prev_next  = NIL;
                            node_raddr = heads_rd_reg;
                            state_next = ST_FIND;
                        end
                    end
                    default: begin
                        state_next = ST_RESULT;
                    end
                endcase
            end

            // Follow the chain to its tail and hook the new node on.
            ST_INS_WALK: begin
                if (link_eff == NIL) begin
                    link_we    = 1'b1;
                    link_waddr = cur_reg;
                    link_wdata = alloc_reg;
                    state_next = ST_RESULT;
                end else begin
                    cur_next   = link_eff;
                    node_raddr = link_eff;
                end
            end

            // Compare one node per cycle; unlink the first match on remove.
            ST_FIND: begin
                if (data_rd_reg.key == cmd_reg.key) begin
                    res_status_next = chrs_pkg::STS_OK;
                    res_b_next      = data_rd_reg.b_value;
                    res_c_next      = data_rd_reg.c_value;
                    if (cmd_reg.op == chrs_pkg::OP_REMOVE) begin
                        if (prev_reg != NIL) begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg;
                            link_wdata = link_eff;
                        end else begin
                            heads_we    = 1'b1;
                            heads_waddr = bkt_reg;
                            heads_wdata = link_eff;
                        end
                        state_next = ST_REM_FREE;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else if (link_eff == NIL) begin
                    state_next = ST_RESULT;
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = link_eff;
                    node_raddr = link_eff;
                end
            end

            // Push the removed node onto the free list.
            ST_REM_FREE: begin
                link_we        = 1'b1;
                link_waddr     = cur_reg;
                link_wdata     = free_head_reg;
                free_head_next = cur_reg;
                if (count_reg != '0) begin
                    count_next = count_reg - NW'(1);
                end
                state_next = ST_RESULT;
            end

            // Hand the result to the output register once it is free.
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_b_next      = res_b_reg;
                    m_c_next      = res_c_reg;
                    m_total_next  = count_ext[12:0];
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        bkt_reg        <= bkt_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        alloc_reg      <= alloc_next;
        res_status_reg <= res_status_next;
        res_b_reg      <= res_b_next;
        res_c_reg      <= res_c_next;
        m_status_reg   <= m_status_next;
        m_b_reg        <= m_b_next;
        m_c_reg        <= m_c_next;
        m_total_reg    <= m_total_next;
    end

    // Bucket table: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (heads_we) begin
            heads_mem[heads_waddr] <= heads_wdata;
        end
        heads_rd_reg <= heads_mem[heads_raddr];
    end

    // Node links: the fresh flag marks nodes still in their initial run.
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr[AW-1:0]] <= link_wdata;
        end
        link_rd_reg    <= link_mem[node_raddr[AW-1:0]];
        link_addr_reg  <= node_raddr;
        link_fresh_reg <= (node_raddr >= fresh_reg);
    end

    // Node data, read at the same address as the links.
    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[data_waddr[AW-1:0]] <= '{key:     cmd_reg.key,
                                              b_value: cmd_reg.b_value,
                                              c_value: cmd_reg.c_value};
        end
        data_rd_reg <= data_mem[node_raddr[AW-1:0]];
    end

`ifndef SYNTHESIS
    // The row count never exceeds the pool.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NW'(POOL))
        else $error("row count exceeds pool size");

    // Allocation from the initial run never passes the end of the pool.
    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= NW'(POOL))
        else $error("fresh node mark beyond pool");

    // No result appears while the bucket table is being cleared.
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !m_valid_reg)
        else $error("result during clearing pass");

    // A full pool means the insert changed nothing.
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_HEAD && cmd_reg.op == chrs_pkg::OP_INSERT && free_head_reg == NIL
        |=> count_reg == $past(count_reg) && free_head_reg == NIL)
        else $error("full insert modified pool state");

    // A pending output item holds while the consumer stalls.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_b_reg) && $stable(m_status_reg))
        else $error("output item changed under stall");
`endif

endmodule

// ----- sv/chained_hash_row_store.sv -----
// Top level of the chained hash row store: front end, command queue, engine.
// Depends on chrs_pkg, chrs_front, chrs_queue and chrs_engine.
//
//  Channel  Handshake          Payload
//  s_       s_valid/s_ready    s_action, s_key, s_b_value, s_c_value
//  m_       m_valid/m_ready    m_status, m_b_out, m_c_out, m_row_total
//
// A lookup or remove fetches its bucket head, then compares the chain node by node
// up to the match or the chain end; a remove that finds its row then frees it. An
// insert takes a free node and walks its bucket's chain node by node to the tail. The
// chain walk reads one node per cycle. After reset a clearing pass empties every
// bucket, during which s_ready stays low. The queue holds two items and the output
// register one, so the input takes items while a result waits until the queue fills.
module chained_hash_row_store #(
    parameter int BUCKETS = chrs_pkg::BUCKETS_DEF,
    parameter int POOL    = chrs_pkg::POOL_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_key,
    input  logic [63:0] s_b_value,
    input  logic [63:0] s_c_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_b_out,
    output logic [63:0] m_c_out,
    output logic [12:0] m_row_total
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           q_valid;
    logic           engine_busy;
    chrs_pkg::cmd_t push_cmd;
    chrs_pkg::cmd_t q_cmd;

    // Accept and decode request items.
    chrs_front u_front (
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_key       (s_key),
        .s_b_value   (s_b_value),
        .s_c_value   (s_c_value),
        .engine_busy (engine_busy),
        .queue_full  (queue_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Decouple the front end from the chain walker.
    chrs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // Carry out requests against the table and the node pool.
    chrs_engine #(
        .BUCKETS (BUCKETS),
        .POOL    (POOL)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .pop         (pop),
        .busy        (engine_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_b_out     (m_b_out),
        .m_c_out     (m_c_out),
        .m_row_total (m_row_total)
    );

endmodule

// ----- bench/tb_chained_hash_row_store.sv -----
// Self-checking testbench for chained_hash_row_store: directed table, then
// random traffic, scored against a behavioral copy of the hash store or, for typed rows, their own answers.
// Depends on chrs_pkg and the RTL of chained_hash_row_store.
`timescale 1ns / 1ps

module tb_chained_hash_row_store;

    localparam int          NBKT       = chrs_pkg::BUCKETS_DEF;
    localparam int          NPOOL      = chrs_pkg::POOL_DEF;
    localparam int          NULL_LINK  = NPOOL;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam logic [63:0] ONES       = {64{1'b1}};
    localparam int          N_RANDOM   = 1030;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] b_out;
        logic [63:0] c_out;
        logic [12:0] total;
    } answer_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [63:0] key;
        logic [63:0] b;
        logic [63:0] c;
        logic        typed;
        answer_t     ans;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [63:0] s_key = '0;
    logic [63:0] s_b_value = '0;
    logic [63:0] s_c_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [63:0] m_b_out;
    logic [63:0] m_c_out;
    logic [12:0] m_row_total;

    chained_hash_row_store uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action), .s_key(s_key),
        .s_b_value(s_b_value), .s_c_value(s_c_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status), .m_b_out(m_b_out),
        .m_c_out(m_c_out), .m_row_total(m_row_total)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow copy of the table, the pool and the free list.
    int          shadow_heads [NBKT];
    logic [63:0] shadow_keys [NPOOL];
    logic [63:0] shadow_b [NPOOL];
    logic [63:0] shadow_c [NPOOL];
    int          shadow_links [NPOOL];
    int          shadow_free;
    int          shadow_rows;

    answer_t     pending_answers [$];
    logic [63:0] live_keys [$];
    int          mismatches = 0;
    int          burst_left = 0;
    bit          hold_go = 1'b0;

    // Apply one request to the shadow store and return the answer it earns.
    function automatic answer_t hash_store_step(logic [1:0] act, logic [63:0] key,
                                                logic [63:0] b, logic [63:0] c);
        answer_t a;
        int bk;
        int n;
        int cur;
        int prev;
        int steps;
        a = '{status: chrs_pkg::STS_MISS, b_out: '0, c_out: '0, total: '0};
        bk = int'(key & 64'(NBKT - 1));
        if (act == chrs_pkg::ACT_INSERT) begin
            n = shadow_free;
            if (n >= NPOOL) begin
                a.status = chrs_pkg::STS_FULL;
            end else begin
                shadow_free = shadow_links[n];
                shadow_keys[n] = key;
                shadow_b[n] = b;
                shadow_c[n] = c;
                shadow_links[n] = NULL_LINK;
                cur = shadow_heads[bk];
                if (cur >= NPOOL) begin
                    shadow_heads[bk] = n;
                end else begin
                    steps = 0;
                    while (shadow_links[cur] < NPOOL && steps < NPOOL) begin
                        cur = shadow_links[cur];
                        steps++;
                    end
                    shadow_links[cur] = n;
                end
                shadow_rows++;
                a.status = chrs_pkg::STS_OK;
            end
        end else if (act == chrs_pkg::ACT_LOOKUP || act == chrs_pkg::ACT_REMOVE) begin
            prev = NULL_LINK;
            cur = shadow_heads[bk];
            steps = 0;
            while (cur < NPOOL && steps < NPOOL && a.status != chrs_pkg::STS_OK) begin
                if (shadow_keys[cur] == key) begin
                    a.status = chrs_pkg::STS_OK;
                    a.b_out = shadow_b[cur];
                    a.c_out = shadow_c[cur];
                    if (act == chrs_pkg::ACT_REMOVE) begin
                        if (prev < NPOOL) shadow_links[prev] = shadow_links[cur];
                        else shadow_heads[bk] = shadow_links[cur];
                        shadow_links[cur] = shadow_free;
                        shadow_free = cur;
                        if (shadow_rows > 0) shadow_rows--;
                    end
                end else begin
                    prev = cur;
                    cur = shadow_links[cur];
                    steps++;
                end
            end
        end
        a.total = 13'(shadow_rows);
        return a;
    endfunction

    // Offer one item in bursts with random gaps, then wait for its acceptance.
    task automatic offer_item(logic [1:0] act, logic [63:0] key, logic [63:0] b,
                              logic [63:0] c, bit typed, answer_t typed_ans);
        answer_t a;
        int i;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_action <= act;
        s_key <= key;
        s_b_value <= b;
        s_c_value <= c;
        do @(posedge aclk); while (!s_ready);
        a = hash_store_step(act, key, b, c);
        pending_answers = {pending_answers, (typed ? typed_ans : a)};
        // Track keys held, so random requests often hit a stored row.
        if (act == chrs_pkg::ACT_INSERT && a.status == chrs_pkg::STS_OK)
            live_keys = {live_keys, key};
        if (act == chrs_pkg::ACT_REMOVE && a.status == chrs_pkg::STS_OK) begin
            for (i = 0; i < live_keys.size(); i++) begin
                if (live_keys[i] == key) begin
                    live_keys.delete(i);
                    break;
                end
            end
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Receiver: check each accepted result and stall on its own pattern.
    int  stall_mode = 0;
    int  stall_tick = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    answer_t got;
    answer_t want;

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            got = '{status: m_status, b_out: m_b_out, c_out: m_c_out, total: m_row_total};
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d b %h c %h total %0d",
                             got.status, got.b_out, got.c_out, got.total);
            end else begin
                want = pending_answers.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %h %h %0d / got %0d %h %h %0d",
                                 want.status, want.b_out, want.c_out, want.total,
                                 got.status, got.b_out, got.c_out, got.total);
                end
            end
        end
        stall_tick++;
        if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 2);
        if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_mode == 0) begin
            m_ready <= 1'b1;
        end else if (stall_mode == 1) begin
            m_ready <= (stall_tick % 7) >= 3;
        end else begin
            m_ready <= $urandom_range(0, 3) != 0;
        end
    end

    // Directed table; rows marked typed carry an answer that is plain at a glance.
    localparam answer_t NO_ANS = '{status: chrs_pkg::STS_MISS, b_out: '0, c_out: '0,
                                   total: '0};
    dir_row_t dir_tab [20] = '{
        '{chrs_pkg::ACT_LOOKUP, 64'd0, 64'd0, 64'd0, 1'b1,
          '{chrs_pkg::STS_MISS, 64'd0, 64'd0, 13'd0}},
        '{chrs_pkg::ACT_REMOVE, ONES, ONES, ONES, 1'b1,
          '{chrs_pkg::STS_MISS, 64'd0, 64'd0, 13'd0}},
        '{ACT_UNUSED, 64'd5, ONES, ONES, 1'b1,
          '{chrs_pkg::STS_MISS, 64'd0, 64'd0, 13'd0}},
        '{chrs_pkg::ACT_INSERT, 64'd0, ONES, 64'd0, 1'b1,
          '{chrs_pkg::STS_OK, 64'd0, 64'd0, 13'd1}},
        '{chrs_pkg::ACT_INSERT, ONES, 64'd0, ONES, 1'b1,
          '{chrs_pkg::STS_OK, 64'd0, 64'd0, 13'd2}},
        '{chrs_pkg::ACT_INSERT, 64'd0, 64'h1234, 64'h5678, 1'b1,
          '{chrs_pkg::STS_OK, 64'd0, 64'd0, 13'd3}},
        '{chrs_pkg::ACT_INSERT, 64'd1024, 64'd7, 64'd9, 1'b1,
          '{chrs_pkg::STS_OK, 64'd0, 64'd0, 13'd4}},
        '{chrs_pkg::ACT_LOOKUP, 64'd0, 64'd0, 64'd0, 1'b1,
          '{chrs_pkg::STS_OK, ONES, 64'd0, 13'd4}},
        '{chrs_pkg::ACT_LOOKUP, 64'd1024, 64'd0, 64'd0, 1'b0, NO_ANS},
        '{chrs_pkg::ACT_LOOKUP, 64'd2048, 64'd0, 64'd0, 1'b1,
          '{chrs_pkg::STS_MISS, 64'd0, 64'd0, 13'd4}},
        '{chrs_pkg::ACT_REMOVE, 64'd0, 64'd0, 64'd0, 1'b1,
          '{chrs_pkg::STS_OK, ONES, 64'd0, 13'd3}},
        '{chrs_pkg::ACT_LOOKUP, 64'd0, 64'd0, 64'd0, 1'b0, NO_ANS},
        '{chrs_pkg::ACT_REMOVE, 64'd1024, 64'd0, 64'd0, 1'b0, NO_ANS},
        '{chrs_pkg::ACT_REMOVE, 64'd0, 64'd0, 64'd0, 1'b0, NO_ANS},
        '{chrs_pkg::ACT_REMOVE, 64'd0, 64'd0, 64'd0, 1'b1,
          '{chrs_pkg::STS_MISS, 64'd0, 64'd0, 13'd1}},
        '{chrs_pkg::ACT_LOOKUP, ONES, 64'd0, 64'd0, 1'b0, NO_ANS},
        '{ACT_UNUSED, ONES, 64'd0, 64'd0, 1'b0, NO_ANS},
        '{chrs_pkg::ACT_REMOVE, ONES, 64'd0, 64'd0, 1'b1,
          '{chrs_pkg::STS_OK, 64'd0, ONES, 13'd0}},
        '{chrs_pkg::ACT_INSERT, 64'h8000_0000_0000_03FF, {32{2'b10}}, {32{2'b01}}, 1'b1,
          '{chrs_pkg::STS_OK, 64'd0, 64'd0, 13'd1}},
        '{chrs_pkg::ACT_REMOVE, 64'h8000_0000_0000_03FF, 64'd0, 64'd0, 1'b0, NO_ANS}
    };

    // Main stimulus: directed rows, then random traffic under a long output hold.
    initial begin
        int i;
        int r;
        logic [1:0]  act;
        logic [63:0] key;
        for (i = 0; i < NBKT; i++) shadow_heads[i] = NULL_LINK;
        for (i = 0; i < NPOOL; i++) begin
            shadow_links[i] = i + 1;
            shadow_keys[i] = '0;
            shadow_b[i] = '0;
            shadow_c[i] = '0;
        end
        shadow_free = 0;
        shadow_rows = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < 20; i++)
            offer_item(dir_tab[i].act, dir_tab[i].key, dir_tab[i].b, dir_tab[i].c,
                       dir_tab[i].typed, dir_tab[i].ans);

        // The receiver holds off for a long stretch so the input backs up.
        hold_go = 1'b1;

        // Random traffic over few buckets so chains and duplicates form.
        for (i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (r < 5) act = ACT_UNUSED;
            else if (r < (live_keys.size() > 120 ? 25 : 50)) act = chrs_pkg::ACT_INSERT;
            else if (r < 75) act = chrs_pkg::ACT_LOOKUP;
            else act = chrs_pkg::ACT_REMOVE;
            if (act != chrs_pkg::ACT_INSERT && live_keys.size() > 0
                && $urandom_range(0, 9) < 7) begin
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            end else if (act == chrs_pkg::ACT_INSERT && live_keys.size() > 0
                         && $urandom_range(0, 9) == 0) begin
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            end else if ($urandom_range(0, 9) == 0) begin
                key = rand64();
            end else begin
                key = rand64();
                key[9:0] = 10'($urandom_range(0, 31));
            end
            offer_item(act, key, rand64(), rand64(), 1'b0, NO_ANS);
        end
        s_valid <= 1'b0;

        while (pending_answers.size() > 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("[chained_hash_row_store] OK");
        end else begin
            $display("[chained_hash_row_store] ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #8_000_000;
        $display("[chained_hash_row_store] ERROR");
        $finish;
    end

endmodule
